/* design/msr_chk_pkg.sv */
// Shared types and constants for the MSR list record checker.
package msr_chk_pkg;

   localparam int LEN_W = 13;
   localparam int CODE_W = 3;

   localparam logic [31:0] MSR_FS_BASE     = 32'hC000_0100;
   localparam logic [31:0] MSR_GS_BASE     = 32'hC000_0101;
   localparam logic [31:0] MSR_UCODE_WRITE = 32'h0000_0079;
   localparam logic [31:0] MSR_UCODE_REV   = 32'h0000_008B;
   localparam logic [31:0] MSR_SMM_MON_CTL = 32'h0000_009B;
   localparam logic [31:0] MSR_SMBASE      = 32'h0000_009E;
   localparam logic [23:0] X2APIC_PAGE     = 24'h00_0008;

   localparam logic [1:0] CSR_LIST_KIND     = 2'd0;
   localparam logic [1:0] CSR_MAX_LIST_CODE = 2'd1;
   localparam logic [1:0] CSR_LIST_LENGTH   = 2'd2;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_COUNT     = 3'd1,
      ST_MEMORY    = 3'd2,
      ST_RESERVED  = 3'd3,
      ST_FORBIDDEN = 3'd4,
      ST_POLICY    = 3'd5,
      ST_SKIPPED   = 3'd6
   } status_type;

   // Classified record as it travels from the front to the back.
   typedef struct packed {
      logic        first;
      status_type  err;
      logic [31:0] idx;
      logic [63:0] val;
   } rec_type;

   typedef struct packed {
      logic              store;
      logic [CODE_W-1:0] max_code;
      logic [LEN_W-1:0]  length;
   } cfg_type;

endpackage

/* design/msr_list_record_checker_top.sv */
// Top level of the MSR list record checker.
//
// Checks a VM MSR load or store list one 16-byte record per item. A front end
// classifies each record (read error, nonzero reserved word, forbidden index,
// policy reject), a small queue decouples it from the back end, which numbers
// records, applies the list-length capability check, stops at the first
// failure and registers one result item per record. Throughput is one item
// per clock while results are taken; a request is written into the queue
// and then into the result register before its result is valid. Either side
// may stall on its own: requests are taken while the queue has room,
// including while a result waits. Write the CSRs only while the block is
// idle. A record with req_tuser set starts a new list. Store lists report
// value 0; failed and skipped records report index and value 0.
module msr_list_record_checker_top
   import msr_chk_pkg::*;
#(
   parameter int ENTRIES_PER_STEP = 512,   // allowed entries per capability step
   parameter int FIFO_DEPTH       = 2      // front-to-back queue depth
) (
   input  logic          clock,
   input  logic          reset,
   // CSR write port: 0 list_kind, 1 max_list_code, 2 list_length
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [12:0]   csr_wdata,
   // request items
   input  logic          req_tvalid,
   output logic          req_tready,
   // msr_index[31:0], reserved_word[63:32], msr_value[127:64],
   // read_failed[128], policy_reject[129], zero pad [135:130]
   input  logic [135:0]  req_tdata,
   // first_record[0]
   input  logic          req_tuser,
   // result items
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[2:0], entry_number[15:3], msr_index_out[47:16], msr_value_out[111:48]
   output logic [111:0]  rsp_tdata,
   output logic          rsp_tlast    // list_done
);

   cfg_type cfg_ff, cfg_in;
   logic    push_valid, push_ready, pop_valid, pop_ready;
   rec_type push_rec, pop_rec;

   // CSR decode; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LIST_KIND:     cfg_in.store    = csr_wdata[0];
            CSR_MAX_LIST_CODE: cfg_in.max_code = csr_wdata[CODE_W-1:0];
            CSR_LIST_LENGTH:   cfg_in.length   = csr_wdata[LEN_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   msr_chk_front u_front (
      .store         (cfg_ff.store),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .first_record  (req_tuser),
      .msr_index     (req_tdata[31:0]),
      .reserved_word (req_tdata[63:32]),
      .msr_value     (req_tdata[127:64]),
      .read_failed   (req_tdata[128]),
      .policy_reject (req_tdata[129]),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_rec      (push_rec)
   );

   msr_chk_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_rec   (push_rec),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_rec    (pop_rec)
   );

   msr_chk_back #(
      .ENTRIES_PER_STEP (ENTRIES_PER_STEP)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_rec    (pop_rec),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* design/msr_chk_front.sv */
// Front end: accepts records and classifies per-record failures.
module msr_chk_front
   import msr_chk_pkg::*;
(
   input  logic          store,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          first_record,
   input  logic [31:0]   msr_index,
   input  logic [31:0]   reserved_word,
   input  logic [63:0]   msr_value,
   input  logic          read_failed,
   input  logic          policy_reject,
   output logic          push_valid,
   input  logic          push_ready,
   output rec_type       push_rec
);

   logic forbidden;

   always_comb begin
      forbidden = (msr_index == MSR_UCODE_WRITE) || (msr_index == MSR_UCODE_REV) ||
                  (msr_index[31:8] == X2APIC_PAGE);
      if (store) begin
         forbidden = forbidden || (msr_index == MSR_SMBASE);
      end else begin
         forbidden = forbidden || (msr_index == MSR_FS_BASE) ||
                     (msr_index == MSR_GS_BASE) || (msr_index == MSR_SMM_MON_CTL);
      end
   end

   always_comb begin
      push_rec.first = first_record;
      push_rec.idx   = msr_index;
      push_rec.val   = store ? 64'd0 : msr_value;
      if (read_failed) begin
         push_rec.err = ST_MEMORY;
      end else if (reserved_word != 32'd0) begin
         push_rec.err = ST_RESERVED;
      end else if (forbidden) begin
         push_rec.err = ST_FORBIDDEN;
      end else if (policy_reject) begin
         push_rec.err = ST_POLICY;
      end else begin
         push_rec.err = ST_OK;
      end
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

/* design/msr_chk_fifo.sv */
// Short queue of classified records between front and back.
module msr_chk_fifo
   import msr_chk_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  rec_type push_rec,
   output logic    pop_valid,
   input  logic    pop_ready,
   output rec_type pop_rec
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   rec_type          mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_rec    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

/* design/msr_chk_back.sv */
// Back end: list progress, count check and registered result.
module msr_chk_back
   import msr_chk_pkg::*;
#(
   parameter int ENTRIES_PER_STEP = 512
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  rec_type       pop_rec,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata,
   output logic          rsp_tlast
);

   localparam int ALW_W = $clog2(ENTRIES_PER_STEP * 8 + 1);
   localparam int CMP_W = (ALW_W > LEN_W) ? ALW_W : LEN_W;

   logic [LEN_W-1:0] cnt_ff, cnt_in, cnt_eff, number;
   logic             failed_ff, failed_in, failed_eff;
   logic             out_valid_ff, out_valid_in;
   status_type       status_ff, status_in;
   logic [LEN_W-1:0] number_ff, number_in;
   logic [31:0]      idx_ff, idx_in;
   logic [63:0]      val_ff, val_in;
   logic             done_ff, done_in;
   logic [CODE_W:0]  code_p1;
   logic [CMP_W-1:0] allowed;
   logic             pop, skip, count_bad;

   assign pop_ready = !out_valid_ff || rsp_tready;
   assign pop       = pop_valid && pop_ready;

   assign code_p1   = {1'b0, cfg.max_code} + (CODE_W + 1)'(1);
   assign allowed   = CMP_W'(ENTRIES_PER_STEP) * CMP_W'(code_p1);
   assign count_bad = CMP_W'(cfg.length) > allowed;

   assign cnt_eff    = pop_rec.first ? '0 : cnt_ff;
   assign failed_eff = pop_rec.first ? 1'b0 : failed_ff;
   assign skip       = failed_eff || (cnt_eff >= cfg.length);
   assign number     = cnt_eff + LEN_W'(1);

   always_comb begin
      cnt_in       = cnt_ff;
      failed_in    = failed_ff;
      out_valid_in = out_valid_ff;
      status_in    = status_ff;
      number_in    = number_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      done_in      = done_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (pop) begin
         out_valid_in = 1'b1;
         cnt_in       = cnt_eff;
         failed_in    = failed_eff;
         number_in    = '0;
         idx_in       = '0;
         val_in       = '0;
         done_in      = 1'b0;
         if (skip) begin
            status_in = ST_SKIPPED;
         end else if (count_bad) begin
            status_in = ST_COUNT;
            failed_in = 1'b1;
            done_in   = 1'b1;
         end else if (pop_rec.err != ST_OK) begin
            status_in = pop_rec.err;
            number_in = number;
            failed_in = 1'b1;
            done_in   = 1'b1;
         end else begin
            status_in = ST_OK;
            number_in = number;
            cnt_in    = number;
            idx_in    = pop_rec.idx;
            val_in    = pop_rec.val;
            done_in   = (number == cfg.length);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         failed_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         failed_ff    <= failed_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      number_ff <= number_in;
      idx_ff    <= idx_in;
      val_ff    <= val_in;
      done_ff   <= done_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {val_ff, idx_ff, number_ff, status_ff};
   assign rsp_tlast  = done_ff;

endmodule

/* dv/msr_verdict_checker.sv */
// Watches the MSR list checker channels, predicts each record verdict and compares.
`timescale 1ns / 1ps

module msr_verdict_checker
   import msr_chk_pkg::*;
#(
   parameter int ENTRIES_PER_STEP = 512
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [12:0]   csr_wdata,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [135:0]  req_tdata,
   input  logic          req_tuser,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [111:0]  rsp_tdata,
   input  logic          rsp_tlast,
   output int            verdict_errors,
   output int            verdicts_owed
);

   localparam int MAX_PRINTED = 100;

   typedef struct packed {
      status_type  status;
      logic [12:0] entry;
      logic [31:0] idx;
      logic [63:0] val;
      logic        done;
   } verdict_type;

   verdict_type pending_verdicts[$];

   // local copy of the CSRs and list progress
   logic        store_list;
   logic [2:0]  cap_code;
   logic [12:0] list_len;
   logic [12:0] records_taken;
   logic        list_dead;

   verdict_type got, want;

   initial verdict_errors = 0;
   initial verdicts_owed = 0;

   task automatic flag_error(input string msg);
      verdict_errors++;
      if (verdict_errors <= MAX_PRINTED)
         $display("[%0t] mismatch: %s", $time, msg);
   endtask

   function automatic bit index_blocked(input logic [31:0] idx, input bit store);
      if (idx == MSR_UCODE_WRITE || idx == MSR_UCODE_REV || idx[31:8] == X2APIC_PAGE)
         return 1'b1;
      if (store)
         return idx == MSR_SMBASE;
      return idx == MSR_FS_BASE || idx == MSR_GS_BASE || idx == MSR_SMM_MON_CTL;
   endfunction

   // verdict for one record; advances list progress
   function automatic verdict_type judge_record(input logic [135:0] data, input logic first);
      verdict_type v;
      logic [31:0] idx;
      logic [31:0] rsv;
      logic [63:0] val;
      int          allowed;
      v = '0;
      idx = data[31:0];
      rsv = data[63:32];
      val = data[127:64];
      allowed = ENTRIES_PER_STEP * (int'(cap_code) + 1);
      if (first) begin
         records_taken = '0;
         list_dead = 1'b0;
      end
      if (list_dead || records_taken >= list_len) begin
         v.status = ST_SKIPPED;
         return v;
      end
      if (int'(list_len) > allowed) begin
         list_dead = 1'b1;
         v.status = ST_COUNT;
         v.done = 1'b1;
         return v;
      end
      v.entry = records_taken + 13'd1;
      if (data[128])
         v.status = ST_MEMORY;
      else if (rsv != '0)
         v.status = ST_RESERVED;
      else if (index_blocked(idx, store_list))
         v.status = ST_FORBIDDEN;
      else if (data[129])
         v.status = ST_POLICY;
      else
         v.status = ST_OK;
      if (v.status != ST_OK) begin
         list_dead = 1'b1;
         v.done = 1'b1;
         return v;
      end
      records_taken = v.entry;
      v.idx = idx;
      v.val = store_list ? 64'd0 : val;
      v.done = (records_taken == list_len);
      return v;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pending_verdicts.delete();
         store_list = 1'b0;
         cap_code = '0;
         list_len = '0;
         records_taken = '0;
         list_dead = 1'b0;
      end else begin
         // a result is registered, so it never belongs to an item taken at this edge
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tdata[2:0]);
            got.entry = rsp_tdata[15:3];
            got.idx = rsp_tdata[47:16];
            got.val = rsp_tdata[111:48];
            got.done = rsp_tlast;
            if (pending_verdicts.size() == 0) begin
               flag_error($sformatf("result with nothing expected, status %0d",
                                    got.status));
            end else begin
               want = pending_verdicts.pop_front();
               if (got.status !== want.status)
                  flag_error($sformatf("status got %0d exp %0d", got.status, want.status));
               if (got.entry !== want.entry)
                  flag_error($sformatf("entry_number got %0d exp %0d", got.entry,
                                       want.entry));
               if (got.idx !== want.idx)
                  flag_error($sformatf("msr_index_out got %h exp %h", got.idx, want.idx));
               if (got.val !== want.val)
                  flag_error($sformatf("msr_value_out got %h exp %h", got.val, want.val));
               if (got.done !== want.done)
                  flag_error($sformatf("list_done got %b exp %b", got.done, want.done));
            end
         end
         if (req_tvalid && req_tready)
            pending_verdicts.push_back(judge_record(req_tdata, req_tuser));
         if (csr_we) begin
            case (csr_index)
               CSR_LIST_KIND:     store_list = csr_wdata[0];
               CSR_MAX_LIST_CODE: cap_code = csr_wdata[2:0];
               CSR_LIST_LENGTH:   list_len = csr_wdata;
               default: ;
            endcase
         end
      end
      verdicts_owed = pending_verdicts.size();
   end

endmodule

/* dv/tb.sv */
// Testbench top for the MSR list record checker: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb
   import msr_chk_pkg::*;
();

   localparam int ENTRIES_PER_STEP = 512;
   localparam int ITEM_TARGET      = 1650;
   localparam int TAIL_ITEMS       = 200;    // last stretch runs with no idling
   localparam int LONG_HOLD        = 80;     // receiver hold-off, cycles
   localparam int CYCLE_LIMIT      = 400000;

   typedef struct packed {
      logic        first;
      logic [31:0] idx;
      logic [31:0] rsv;
      logic [63:0] val;
      logic        rdf;
      logic        rej;
   } msr_rec_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_we = 1'b0;
   logic [1:0]    csr_index = CSR_LIST_KIND;
   logic [12:0]   csr_wdata = '0;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   // msr_index[31:0], reserved_word[63:32], msr_value[127:64],
   // read_failed[128], policy_reject[129], zero pad [135:130]
   logic [135:0]  req_tdata = '0;
   // first_record[0]
   logic          req_tuser = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   // status[2:0], entry_number[15:3], msr_index_out[47:16], msr_value_out[111:48]
   logic [111:0]  rsp_tdata;
   logic          rsp_tlast;

   int  verdict_errors;
   int  verdicts_owed;
   int  items_sent = 0;
   int  cycle_count = 0;
   bit  phase_idle = 1'b1;   // random idling allowed in this phase
   bit  tail_mode = 1'b0;    // final stretch: both sides run flat out
   bit  hold_req = 1'b0;     // asks the receiver for one long hold-off
   bit  cur_store = 1'b0;    // list kind currently programmed

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   msr_list_record_checker_top #(.ENTRIES_PER_STEP(ENTRIES_PER_STEP)) uut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   msr_verdict_checker #(.ENTRIES_PER_STEP(ENTRIES_PER_STEP)) u_checker (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .verdict_errors(verdict_errors), .verdicts_owed(verdicts_owed)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side: ready most of the time, random stall bursts, and a long
   // hold-off on request so the internal queue fills and req_tready drops.
   // At most one assignment to rsp_tready per clock step.
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (phase_idle && !tail_mode && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic msr_rec_type mk_rec(input logic first, input logic [31:0] idx,
                                          input logic [31:0] rsv, input logic [63:0] val,
                                          input logic rdf, input logic rej);
      msr_rec_type r;
      r.first = first;
      r.idx = idx;
      r.rsv = rsv;
      r.val = val;
      r.rdf = rdf;
      r.rej = rej;
      return r;
   endfunction

   // Mostly well-formed records; fault_pct percent carry one fault or noise.
   function automatic msr_rec_type rand_record(input bit first, input int fault_pct);
      msr_rec_type r;
      r = mk_rec(first, $urandom, '0, {$urandom, $urandom}, 1'b0, 1'b0);
      // indices right next to the forbidden ones, plus kind-dependent legal ones
      case ($urandom_range(0, 11))
         0: r.idx = MSR_UCODE_WRITE - 32'd1;
         1: r.idx = MSR_UCODE_REV + 32'd1;
         2: r.idx = 32'h0000_07FF;
         3: r.idx = 32'h0000_0900;
         4: r.idx = MSR_GS_BASE + 32'd1;
         5: r.idx = cur_store ? MSR_FS_BASE : MSR_SMBASE;
         6: r.idx = cur_store ? MSR_GS_BASE : MSR_SMM_MON_CTL + 32'd1;
         7: r.idx = cur_store ? MSR_SMM_MON_CTL : MSR_SMBASE - 32'd1;
         8: r.idx = $urandom_range(0, 255);
         default: ;
      endcase
      case ($urandom_range(0, 7))
         0: r.val = '0;
         1: r.val = '1;
         default: ;
      endcase
      if ($urandom_range(0, 99) < fault_pct) begin
         case ($urandom_range(0, 4))
            0: r.rdf = 1'b1;
            1: r.rsv = $urandom | (32'd1 << $urandom_range(0, 31));
            2: begin
               case ($urandom_range(0, 5))
                  0: r.idx = MSR_UCODE_WRITE;
                  1: r.idx = MSR_UCODE_REV;
                  2: r.idx = {X2APIC_PAGE, 8'($urandom)};
                  3: r.idx = cur_store ? MSR_SMBASE : MSR_FS_BASE;
                  4: r.idx = cur_store ? MSR_SMBASE : MSR_GS_BASE;
                  default: r.idx = cur_store ? MSR_SMBASE : MSR_SMM_MON_CTL;
               endcase
            end
            3: r.rej = 1'b1;
            default: begin
               // noise: every field random, faults may stack
               r.rsv = $urandom;
               r.rdf = 1'($urandom);
               r.rej = 1'($urandom);
            end
         endcase
      end
      return r;
   endfunction

   // Offer one item and return at the edge where it is taken. Valid stays
   // high into the next item unless a gap is drawn.
   task automatic send_record(input msr_rec_type r);
      if (phase_idle && !tail_mode && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.first;
      req_tdata <= {6'b0, r.rej, r.rdf, r.val, r.rsv, r.idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (items_sent >= ITEM_TARGET - TAIL_ITEMS)
         tail_mode = 1'b1;
   endtask

   // Stop offering and wait until every result is back, then let the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (verdicts_owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Program all three CSRs on consecutive edges; block must be idle.
   task automatic write_cfg(input bit kind, input int code, input int len);
      cur_store = kind;
      csr_we <= 1'b1;
      csr_index <= CSR_LIST_KIND;
      csr_wdata <= 13'(kind);
      @(posedge clock);
      csr_index <= CSR_MAX_LIST_CODE;
      csr_wdata <= 13'(code);
      @(posedge clock);
      csr_index <= CSR_LIST_LENGTH;
      csr_wdata <= 13'(len);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // One configuration, a few lists of random content, then drain.
   task automatic random_phase();
      int kind, code, len, allowed, n_lists, n_recs, fault;
      kind = $urandom_range(0, 1);
      code = $urandom_range(0, 7);
      case ($urandom_range(0, 19))
         0: len = 0;
         1, 2: begin
            // longer than the capability allows
            code = $urandom_range(0, 6);
            allowed = ENTRIES_PER_STEP * (code + 1);
            len = $urandom_range(0, 1) ? allowed + 1 : $urandom_range(allowed + 1, 4096);
         end
         3: len = $urandom_range(13, 40);
         default: len = $urandom_range(1, 12);
      endcase
      write_cfg(1'(kind), code, len);
      phase_idle = $urandom_range(0, 3) != 0;
      if (!tail_mode && $urandom_range(0, 9) == 0)
         hold_req = 1'b1;
      fault = ($urandom_range(0, 3) == 0) ? 25 : 4;
      n_lists = $urandom_range(1, 4);
      repeat (n_lists) begin
         if (len == 0 || len > ENTRIES_PER_STEP * (code + 1))
            n_recs = $urandom_range(1, 3);
         else begin
            case ($urandom_range(0, 19))
               0, 1, 2: n_recs = len + $urandom_range(1, 3);   // run past the end
               3, 4, 5: n_recs = $urandom_range(1, len);       // cut short by a new list
               default: n_recs = len;
            endcase
         end
         for (int i = 0; i < n_recs; i++)
            send_record(rand_record(i == 0, fault));
      end
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // reset config has length 0: everything is skipped
      send_record(mk_rec(1'b1, 32'h0000_0010, '0, 64'h1, 1'b0, 1'b0));
      send_record(mk_rec(1'b0, 32'h0000_0011, '0, 64'h2, 1'b0, 1'b0));
      drain();

      write_cfg(1'b0, 0, 3);
      send_record(mk_rec(1'b1, 32'h0, '0, 64'h0, 1'b0, 1'b0));
      send_record(mk_rec(1'b0, 32'hFFFF_FFFF, '0, '1, 1'b0, 1'b0));
      send_record(mk_rec(1'b0, 32'h0000_07FF, '0, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0));
      send_record(mk_rec(1'b0, 32'h0000_0001, '0, 64'h5, 1'b0, 1'b0));   // beyond the end
      // read error outranks a nonzero reserved word; then skipped after failure
      send_record(mk_rec(1'b1, 32'h0000_0001, 32'h1, 64'h5, 1'b1, 1'b1));
      send_record(mk_rec(1'b0, 32'h0000_0002, '1, 64'h6, 1'b0, 1'b0));
      // reserved word outranks a forbidden index
      send_record(mk_rec(1'b1, MSR_UCODE_WRITE, 32'h8000_0000, 64'h7, 1'b0, 1'b0));
      send_record(mk_rec(1'b1, MSR_UCODE_WRITE, '0, 64'h8, 1'b0, 1'b0));
      send_record(mk_rec(1'b1, MSR_UCODE_REV, '0, 64'h9, 1'b0, 1'b0));
      send_record(mk_rec(1'b1, 32'h0000_0800, '0, 64'hA, 1'b0, 1'b0));
      send_record(mk_rec(1'b1, 32'h0000_08FF, '0, 64'hB, 1'b0, 1'b0));
      send_record(mk_rec(1'b1, MSR_FS_BASE, '0, 64'hC, 1'b0, 1'b0));
      send_record(mk_rec(1'b1, MSR_GS_BASE, '0, 64'hD, 1'b0, 1'b0));
      send_record(mk_rec(1'b1, MSR_SMM_MON_CTL, '0, 64'hE, 1'b0, 1'b1));
      // SMBASE is legal on load lists, so the policy verdict decides
      send_record(mk_rec(1'b1, MSR_SMBASE, '0, 64'hF, 1'b0, 1'b1));
      send_record(mk_rec(1'b1, 32'h0000_0012, '0, 64'h10, 1'b0, 1'b1));
      drain();

      // store list: value forced to zero, SMBASE forbidden, FS base / SMM ctl legal
      write_cfg(1'b1, 7, 2);
      send_record(mk_rec(1'b1, MSR_SMBASE, '0, 64'h11, 1'b0, 1'b0));
      send_record(mk_rec(1'b1, MSR_FS_BASE, '0, '1, 1'b0, 1'b0));
      send_record(mk_rec(1'b0, MSR_SMM_MON_CTL, '0, 64'h12, 1'b0, 1'b0));
      send_record(mk_rec(1'b0, 32'h0000_0013, '0, 64'h13, 1'b0, 1'b0));
      drain();

      // one entry over the capability: count failure, then skipped
      write_cfg(1'b0, 0, ENTRIES_PER_STEP + 1);
      send_record(mk_rec(1'b1, 32'h0000_0014, '0, 64'h14, 1'b0, 1'b0));
      send_record(mk_rec(1'b0, 32'h0000_0015, '0, 64'h15, 1'b0, 1'b0));
      drain();

      // --- long lists ---
      // clean load list past one capability step, with a long receiver hold-off
      write_cfg(1'b0, 1, 520);
      phase_idle = 1'b1;
      hold_req = 1'b1;
      for (int i = 0; i < 522; i++)
         send_record(rand_record(i == 0, 0));
      drain();

      // largest capability and the longest list it allows: partly walked, then restarted
      write_cfg(1'b1, 7, 4096);
      hold_req = 1'b1;
      for (int i = 0; i < 48; i++)
         send_record(rand_record(i == 0, 0));
      for (int i = 0; i < 6; i++)
         send_record(rand_record(i == 0, 20));
      drain();

      // --- random phases ---
      while (items_sent < ITEM_TARGET)
         random_phase();

      drain();
      repeat (8) @(posedge clock);
      if (verdict_errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* filelist.f */
design/msr_chk_pkg.sv
design/msr_chk_front.sv
design/msr_chk_fifo.sv
design/msr_chk_back.sv
design/msr_list_record_checker_top.sv
dv/msr_verdict_checker.sv
dv/tb.sv
